/* rtl/rn256_pkg.sv */
// ----------------------------------------------------------------------------
// rn256_pkg
// Shared types and constants for the 256-way radix node child table.
// ----------------------------------------------------------------------------
`default_nettype none

package rn256_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int REF_W      = 32;
    localparam int CNT_W      = 9;
    localparam int GRP_BITS   = 4;
    localparam int GRP_SIZE   = 1 << GRP_BITS;
    localparam int NUM_GRP    = TABLE_SIZE / GRP_SIZE;

    localparam logic [IDX_W-1:0] KEY_BIAS      = 8'h80;
    localparam logic [CNT_W-1:0] FULL_COUNT    = 9'd256;
    localparam logic [CNT_W-1:0] UNDERFULL_RST = 9'd48;

    localparam logic [2:0] OP_FIND = 3'd0;
    localparam logic [2:0] OP_SET  = 3'd1;
    localparam logic [2:0] OP_DEL  = 3'd2;
    localparam logic [2:0] OP_NEXT = 3'd3;
    localparam logic [2:0] OP_PREV = 3'd4;

    typedef struct packed {
        logic [2:0]        op;
        logic signed [7:0] key;
        logic [31:0]       child_ref;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [31:0]       ref_out;
        logic signed [7:0] key_out;
        logic [8:0]        occupied;
        logic              is_full;
        logic              is_low;
    } t_rsp;

endpackage

`default_nettype wire

/* rtl/rn256_ram.sv */
// ----------------------------------------------------------------------------
// rn256_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rn256_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/radix_node_256_child_table.sv */
// ----------------------------------------------------------------------------
// radix_node_256_child_table
// 256-entry child table of a radix tree node with find, set, delete and
// nearest occupied key search, plus an occupancy count and fill flags.
// ----------------------------------------------------------------------------
// result: registered from the exec state once its request word is accepted,
//   held back only while a previous result is still stalled
// requests: one at a time, idle then exec, for the read-then-write pair on the
//   reference ram and the two-level priority search over the occupancy bits
// reset: occupancy bits and count clear at once (empty entries read as zero),
//   no clearing pass; underfull limit returns to 48
// ----------------------------------------------------------------------------
`default_nettype none

module radix_node_256_child_table
    import rn256_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CNT_W-1:0] i_cfg_wr_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_req             i_in_word,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_rsp                  o_out_word
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                      r_state;
    logic [2:0]                r_op;
    logic [IDX_W-1:0]          r_idx;
    logic [REF_W-1:0]          r_ref;
    logic [TABLE_SIZE-1:0]     r_occ;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_limit;
    logic [NUM_GRP-1:0]        r_grp_hit;
    logic [GRP_BITS-1:0]       r_grp_pos [NUM_GRP];
    logic                      r_out_valid;
    t_rsp                      r_out_word;

    logic                      w_accept;
    logic                      w_commit;
    logic [IDX_W-1:0]          w_in_idx;
    logic [REF_W-1:0]          w_rd_data;
    logic [NUM_GRP-1:0]        n_grp_hit;
    logic [GRP_BITS-1:0]       n_grp_pos [NUM_GRP];
    logic [CNT_W-1:0]          n_count;
    logic                      n_occ_bit;
    logic                      w_occ_wr;
    t_rsp                      n_out_word;

    assign w_in_idx   = $unsigned(i_in_word.key) ^ KEY_BIAS;
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_commit   = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != ST_IDLE);

    rn256_ram #(
        .WIDTH(REF_W),
        .DEPTH(TABLE_SIZE)
    ) u_ref_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_commit && (r_op == OP_SET)),
        .i_wr_addr (r_idx),
        .i_wr_data (r_ref),
        .i_rd_addr (w_accept ? w_in_idx : r_idx),
        .o_rd_data (w_rd_data)
    );

    // first level of the search: per-group masked hit and best bit position
    always_comb begin
        logic [GRP_SIZE-1:0]  grp;
        logic [GRP_SIZE-1:0]  mask;
        logic [GRP_BITS-1:0]  hi;
        logic [GRP_BITS-1:0]  lo;
        logic                 fwd;
        hi  = w_in_idx[IDX_W-1:GRP_BITS];
        lo  = w_in_idx[GRP_BITS-1:0];
        fwd = (i_in_word.op == OP_NEXT);
        for (int g = 0; g < NUM_GRP; g++) begin
            grp = r_occ[g*GRP_SIZE +: GRP_SIZE];
            if (GRP_BITS'(g) == hi) begin
                mask = fwd ? ({GRP_SIZE{1'b1}} << lo)
                           : ({GRP_SIZE{1'b1}} >> (GRP_BITS'(GRP_SIZE - 1) - lo));
            end else if (GRP_BITS'(g) > hi) begin
                mask = fwd ? {GRP_SIZE{1'b1}} : '0;
            end else begin
                mask = fwd ? '0 : {GRP_SIZE{1'b1}};
            end
            grp          = grp & mask;
            n_grp_hit[g] = |grp;
            n_grp_pos[g] = '0;
            if (fwd) begin
                for (int b = GRP_SIZE - 1; b >= 0; b--) begin
                    if (grp[b]) begin
                        n_grp_pos[g] = GRP_BITS'(b);
                    end
                end
            end else begin
                for (int b = 0; b < GRP_SIZE; b++) begin
                    if (grp[b]) begin
                        n_grp_pos[g] = GRP_BITS'(b);
                    end
                end
            end
        end
    end

    // second level of the search and the read-modify-write of the entry
    always_comb begin
        logic                old_occ;
        logic                new_occ;
        logic [GRP_BITS-1:0] sel;
        logic [IDX_W-1:0]    found_idx;
        old_occ   = r_occ[r_idx];
        new_occ   = (r_ref != '0);
        sel       = '0;
        if (r_op == OP_NEXT) begin
            for (int g = NUM_GRP - 1; g >= 0; g--) begin
                if (r_grp_hit[g]) begin
                    sel = GRP_BITS'(g);
                end
            end
        end else begin
            for (int g = 0; g < NUM_GRP; g++) begin
                if (r_grp_hit[g]) begin
                    sel = GRP_BITS'(g);
                end
            end
        end
        found_idx  = {sel, r_grp_pos[sel]} ^ KEY_BIAS;
        n_count    = r_count;
        n_occ_bit  = old_occ;
        w_occ_wr   = 1'b0;
        n_out_word = '0;
        unique case (r_op)
            OP_FIND: begin
                n_out_word.ok      = old_occ;
                n_out_word.ref_out = old_occ ? 32'(w_rd_data) : '0;
            end
            OP_SET: begin
                n_out_word.ok = 1'b1;
                w_occ_wr      = 1'b1;
                n_occ_bit     = new_occ;
                if (old_occ && !new_occ) begin
                    n_count = r_count - CNT_W'(1);
                end else if (!old_occ && new_occ) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_DEL: begin
                n_out_word.ok = old_occ;
                w_occ_wr      = 1'b1;
                n_occ_bit     = 1'b0;
                if (old_occ) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_NEXT, OP_PREV: begin
                n_out_word.ok      = |r_grp_hit;
                n_out_word.key_out = (|r_grp_hit) ? $signed(found_idx) : '0;
            end
            default: begin
            end
        endcase
        n_out_word.occupied = n_count;
        n_out_word.is_full  = (n_count == FULL_COUNT);
        n_out_word.is_low   = (n_count <= r_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_occ       <= '0;
            r_count     <= '0;
            r_limit     <= UNDERFULL_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (w_accept) begin
                r_state <= ST_EXEC;
            end else if (w_commit) begin
                r_state <= ST_IDLE;
            end
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
                if (w_occ_wr) begin
                    r_occ[r_idx] <= n_occ_bit;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op      <= i_in_word.op;
            r_idx     <= w_in_idx;
            r_ref     <= REF_W'(i_in_word.child_ref);
            r_grp_hit <= n_grp_hit;
            r_grp_pos <= n_grp_pos;
        end
        if (w_commit) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

/* bench/tb_radix_node_256_child_table.sv */
// ----------------------------------------------------------------------------
// tb_radix_node_256_child_table
// Self-checking bench for the radix node child table. A directed table of
// request words (empty table, extreme keys and references, overwrite, clear,
// delete of an empty entry, searches with and without a neighbor, unused ops)
// is followed by random phases under several underfull limits, including a
// sweep that fills all 256 entries. Every accepted request is run through a
// local model of the table and each result word is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_radix_node_256_child_table
    import rn256_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_UNUSED_A = 3'd5;
    localparam logic [2:0] OP_UNUSED_C = 3'd7;
    localparam logic [2:0] OP_UNUSED_B = 3'd6;
    localparam int HOLD_CYCLES = 120;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [2:0]        op;
        logic signed [7:0] key;
        logic [31:0]       child_ref;
        bit                typed;
        t_rsp              want;
    } t_step;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    t_req             in_word = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    t_rsp             out_word;

    // side info travelling with the request word on the bench side
    bit   word_typed = 1'b0;
    t_rsp word_want = '0;

    bit src_gaps_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    bit hold_req     = 1'b0;

    // table model
    logic [31:0]      tbl_ref  [TABLE_SIZE];
    bit               tbl_used [TABLE_SIZE];
    logic [CNT_W-1:0] used_count;
    logic [CNT_W-1:0] underfull_lim;

    t_rsp result_q [$];
    int   mismatches = 0;
    int   words_in = 0;
    int   results_seen = 0;
    int   peak_used = 0;
    int   op_hits [8];

    t_step directed_steps [25] = '{
        '{OP_FIND, 8'sh80, 32'h0,        1'b1, {1'b0, 32'h0,        8'h00, 9'd0, 1'b0, 1'b1}},
        '{OP_NEXT, 8'sh80, 32'h0,        1'b1, {1'b0, 32'h0,        8'h00, 9'd0, 1'b0, 1'b1}},
        '{OP_PREV, 8'sh7F, 32'h0,        1'b1, {1'b0, 32'h0,        8'h00, 9'd0, 1'b0, 1'b1}},
        '{OP_DEL,  8'sh00, 32'h0,        1'b1, {1'b0, 32'h0,        8'h00, 9'd0, 1'b0, 1'b1}},
        '{OP_SET,  8'sh80, 32'hFFFFFFFF, 1'b1, {1'b1, 32'h0,        8'h00, 9'd1, 1'b0, 1'b1}},
        '{OP_SET,  8'sh7F, 32'h00000001, 1'b1, {1'b1, 32'h0,        8'h00, 9'd2, 1'b0, 1'b1}},
        '{OP_FIND, 8'sh80, 32'h0,        1'b1, {1'b1, 32'hFFFFFFFF, 8'h00, 9'd2, 1'b0, 1'b1}},
        '{OP_FIND, 8'sh7F, 32'h0,        1'b1, {1'b1, 32'h00000001, 8'h00, 9'd2, 1'b0, 1'b1}},
        '{OP_NEXT, 8'sh81, 32'h0,        1'b1, {1'b1, 32'h0,        8'h7F, 9'd2, 1'b0, 1'b1}},
        '{OP_PREV, 8'sh7E, 32'h0,        1'b1, {1'b1, 32'h0,        8'h80, 9'd2, 1'b0, 1'b1}},
        '{OP_NEXT, 8'sh7F, 32'h0,        1'b1, {1'b1, 32'h0,        8'h7F, 9'd2, 1'b0, 1'b1}},
        '{OP_PREV, 8'sh80, 32'h0,        1'b1, {1'b1, 32'h0,        8'h80, 9'd2, 1'b0, 1'b1}},
        '{OP_SET,  8'sh7F, 32'hA5A5A5A5, 1'b1, {1'b1, 32'h0,        8'h00, 9'd2, 1'b0, 1'b1}},
        '{OP_SET,  8'sh80, 32'h0,        1'b1, {1'b1, 32'h0,        8'h00, 9'd1, 1'b0, 1'b1}},
        '{OP_FIND, 8'sh80, 32'h0,        1'b1, {1'b0, 32'h0,        8'h00, 9'd1, 1'b0, 1'b1}},
        '{OP_DEL,  8'sh7F, 32'h0,        1'b1, {1'b1, 32'h0,        8'h00, 9'd0, 1'b0, 1'b1}},
        '{OP_DEL,  8'sh7F, 32'h0,        1'b1, {1'b0, 32'h0,        8'h00, 9'd0, 1'b0, 1'b1}},
        '{OP_UNUSED_A, 8'sh00, 32'h5,    1'b1, {1'b0, 32'h0,        8'h00, 9'd0, 1'b0, 1'b1}},
        '{OP_UNUSED_B, 8'sh7F, 32'hFFFFFFFF, 1'b1, {1'b0, 32'h0,    8'h00, 9'd0, 1'b0, 1'b1}},
        '{OP_UNUSED_C, 8'sh80, 32'h0,    1'b1, {1'b0, 32'h0,        8'h00, 9'd0, 1'b0, 1'b1}},
        '{OP_SET,  8'sh00, 32'h80000000, 1'b0, '0},
        '{OP_SET,  8'shFF, 32'h7FFFFFFF, 1'b0, '0},
        '{OP_NEXT, 8'sh01, 32'h0,        1'b0, '0},
        '{OP_PREV, 8'shFE, 32'h0,        1'b0, '0},
        '{OP_FIND, 8'shFF, 32'h0,        1'b0, '0}
    };

    radix_node_256_child_table i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_word     (in_word),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_word    (out_word)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void write_slot(input logic [7:0] slot, input logic [31:0] child);
        if (tbl_used[slot] && child == '0) begin
            used_count = used_count - CNT_W'(1);
        end else if (!tbl_used[slot] && child != '0) begin
            used_count = used_count + CNT_W'(1);
        end
        tbl_ref[slot]  = child;
        tbl_used[slot] = (child != '0);
    endfunction

    // advance the table model by one request and return its result word
    function automatic t_rsp apply_request(input t_req w);
        t_rsp       r;
        logic [7:0] slot;
        int         i;
        r    = '0;
        slot = w.key ^ KEY_BIAS;
        case (w.op)
            OP_FIND: begin
                r.ok      = tbl_used[slot];
                r.ref_out = tbl_ref[slot];
            end
            OP_SET: begin
                write_slot(slot, w.child_ref);
                r.ok = 1'b1;
            end
            OP_DEL: begin
                if (tbl_used[slot]) begin
                    write_slot(slot, '0);
                    r.ok = 1'b1;
                end
            end
            OP_NEXT: begin
                for (i = int'(slot); i < TABLE_SIZE; i++) begin
                    if (tbl_used[i]) begin
                        r.ok      = 1'b1;
                        r.key_out = i[7:0] ^ KEY_BIAS;
                        break;
                    end
                end
            end
            OP_PREV: begin
                for (i = int'(slot); i >= 0; i--) begin
                    if (tbl_used[i]) begin
                        r.ok      = 1'b1;
                        r.key_out = i[7:0] ^ KEY_BIAS;
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        r.occupied = used_count;
        r.is_full  = (used_count == FULL_COUNT);
        r.is_low   = (used_count <= underfull_lim);
        return r;
    endfunction

    // pick an occupied slot when there is one, else any slot
    function automatic logic [7:0] pick_used_slot();
        logic [7:0] start;
        logic [7:0] probe;
        start = 8'($urandom_range(0, 255));
        for (int k = 0; k < TABLE_SIZE; k++) begin
            probe = start + 8'(k);
            if (tbl_used[probe]) begin
                return probe;
            end
        end
        return start;
    endfunction

    function automatic t_req random_request(input int set_pct, input int del_pct);
        t_req w;
        int   roll;
        roll = $urandom_range(0, 99);
        w.key = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 19))
            0:       w.child_ref = 32'h0;
            1:       w.child_ref = 32'hFFFFFFFF;
            2:       w.child_ref = 32'h1;
            default: w.child_ref = $urandom;
        endcase
        if (roll < 4) begin
            w.op = 3'($urandom_range(OP_UNUSED_A, OP_UNUSED_C));
        end else if (roll < 4 + set_pct) begin
            w.op = OP_SET;
        end else if (roll < 4 + set_pct + del_pct) begin
            w.op = OP_DEL;
            if ($urandom_range(0, 9) < 7) begin
                w.key = pick_used_slot() ^ KEY_BIAS;
            end
        end else begin
            case ($urandom_range(0, 2))
                0:       w.op = OP_FIND;
                1:       w.op = OP_NEXT;
                default: w.op = OP_PREV;
            endcase
            if (w.op == OP_FIND && $urandom_range(0, 1)) begin
                w.key = pick_used_slot() ^ KEY_BIAS;
            end
        end
        return w;
    endfunction

    // called and returns at a falling edge; valid stays up for back-to-back words
    task automatic send_word(input t_req w, input bit typed, input t_rsp want);
        if (src_gaps_on && $urandom_range(0, 4) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid   = 1'b1;
        in_word    = w;
        word_typed = typed;
        word_want  = want;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic send_random(input int count, input int set_pct, input int del_pct);
        for (int n = 0; n < count; n++) begin
            send_word(random_request(set_pct, del_pct), 1'b0, '0);
        end
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (result_q.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [CNT_W-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // receiver: random stall bursts, calm stretches and one long hold-off
    initial begin : sink_side
        int burst_left;
        int calm_left;
        int hold_left;
        burst_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_stall = 1'b1;
            end else if (burst_left > 0) begin
                out_stall = 1'b1;
                burst_left--;
            end else if (calm_left > 0) begin
                out_stall = 1'b0;
                calm_left--;
            end else if (sink_idle_on && $urandom_range(0, 1)) begin
                out_stall  = 1'b1;
                burst_left = $urandom_range(0, 17);
            end else begin
                out_stall = 1'b0;
                calm_left = $urandom_range(0, 30);
            end
        end
    end

    // model update on accepted words, result check on accepted results
    always @(posedge clk) begin : scoreboard
        t_rsp want;
        t_rsp got;
        t_rsp model_rsp;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = out_word;
                results_seen++;
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected result word, none pending (ok=%b occ=%0d)",
                                 got.ok, got.occupied);
                    end
                end else begin
                    want = result_q.pop_front();
                    if (got.ok != want.ok || got.ref_out != want.ref_out
                        || got.key_out != want.key_out || got.occupied != want.occupied
                        || got.is_full != want.is_full
                        || got.is_low != want.is_low) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display({"result %0d: expected ok=%b ref=%h key=%0d",
                                      " occ=%0d full=%b low=%b"},
                                     results_seen, want.ok, want.ref_out, want.key_out,
                                     want.occupied, want.is_full, want.is_low);
                            $display({"result %0d: actual   ok=%b ref=%h key=%0d",
                                      " occ=%0d full=%b low=%b"},
                                     results_seen, got.ok, got.ref_out, got.key_out,
                                     got.occupied, got.is_full, got.is_low);
                        end
                    end
                end
            end
            if (cfg_wr_en) begin
                underfull_lim = cfg_wr_data;
            end
            if (in_valid && !in_stall) begin
                model_rsp = apply_request(in_word);
                result_q.push_back(word_typed ? word_want : model_rsp);
                words_in++;
                op_hits[in_word.op]++;
                if (int'(used_count) > peak_used) begin
                    peak_used = int'(used_count);
                end
            end
        end
    end

    initial begin : stimulus
        t_req w;
        for (int s = 0; s < TABLE_SIZE; s++) begin
            tbl_ref[s]  = '0;
            tbl_used[s] = 1'b0;
        end
        foreach (op_hits[k]) op_hits[k] = 0;
        used_count    = '0;
        underfull_lim = UNDERFULL_RST;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_steps[n]) begin
            w.op        = directed_steps[n].op;
            w.key       = directed_steps[n].key;
            w.child_ref = directed_steps[n].child_ref;
            send_word(w, directed_steps[n].typed, directed_steps[n].want);
        end
        wait_drained();

        // limit 0, grow the table; long receiver hold-off so the block backs up
        write_limit('0);
        src_gaps_on = 1'b0;
        hold_req    = 1'b1;
        send_random(16, 60, 5);
        src_gaps_on = 1'b1;
        send_random(134, 50, 10);
        wait_drained();

        // limit 256, every entry filled, then traffic around the full table
        write_limit(FULL_COUNT);
        for (int s = 0; s < TABLE_SIZE; s++) begin
            w.op        = OP_SET;
            w.key       = 8'(s) ^ KEY_BIAS;
            w.child_ref = $urandom;
            if (w.child_ref == '0) begin
                w.child_ref = 32'h1;
            end
            send_word(w, 1'b0, '0);
        end
        send_random(40, 20, 5);
        wait_drained();

        // one below full, mostly deletes
        write_limit(FULL_COUNT - CNT_W'(1));
        send_random(80, 10, 60);
        wait_drained();

        write_limit(CNT_W'($urandom_range(1, 254)));
        send_random(100, 35, 30);
        wait_drained();

        // closing stretch at full rate
        write_limit(CNT_W'($urandom_range(1, 254)));
        src_gaps_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_random(100, 35, 30);
        wait_drained();
        repeat (8) @(negedge clk);

        $display("%0d request words, %0d result words; finds %0d sets %0d deletes %0d",
                 words_in, results_seen, op_hits[OP_FIND], op_hits[OP_SET], op_hits[OP_DEL]);
        $display("next %0d prev %0d unused ops %0d; peak occupancy %0d, %0d mismatches",
                 op_hits[OP_NEXT], op_hits[OP_PREV],
                 op_hits[OP_UNUSED_A] + op_hits[OP_UNUSED_B] + op_hits[OP_UNUSED_C],
                 peak_used, mismatches);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d results outstanding", result_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
